### rtl/core/lgre_pkg.sv
// Shared types and constants of the Life generation row engine.
`timescale 1ns / 1ps
`default_nettype none

package lgre_pkg;

  // Fixed field widths of the channels and registers.
  localparam int ROW_W         = 64;
  localparam int GRID_WIDTH_W  = 7;
  localparam int GRID_HEIGHT_W = 13;
  localparam int ROW_INDEX_W   = 12;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 7'd64;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 13'd64;

  // Result queue; the depth must be a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  // Neighbour counts run from 0 to 8.
  localparam int NB_CNT_W = 4;
  localparam logic [NB_CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [NB_CNT_W-1:0] SURVIVE_CNT = 4'd2;

  // Bits of one column that a cell shows to its neighbours, already masked.
  typedef struct packed {
    logic upper;
    logic middle;
    logic cur;
  } col_bits_t;

  // Per-transfer control of the cell row.
  typedef struct packed {
    logic load;   // an input row is taken this cycle
    logic clear;  // the row closes the frame, so the column history empties
  } cell_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]       next_row_bits;
    logic [ROW_INDEX_W-1:0] row_index;
    logic                   last_row;
  } result_t;

  typedef struct packed {
    logic                  room_two;
    logic [FIFO_LVL_W-1:0] level;
  } fifo_stat_t;

  // B3/S23 rule for one cell.
  function automatic logic life_rule(input logic alive, input logic [NB_CNT_W-1:0] cnt);
    life_rule = (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

`default_nettype wire

### rtl/core/life_generation_row_engine_top.sv
// Top level of the Life generation row engine (B3/S23, one row per transfer).
//
// Usage: rows of the current generation enter top to bottom on the in_ channel,
// one 64-bit row per transfer, bit x being column x. Results leave on the out_
// channel, each carrying a next-generation row, its row index and a flag for
// the last row of the frame. Both channels transfer when valid is high and
// stall is low. Width and height are set on the cfg_ channel (index 0 width,
// index 1 height), which is always ready; write them only while the block is
// idle. Columns at or beyond the width, and rows beyond the height, are dead.
// The result for row r is produced when row r+1 is transferred in and enters
// the output queue. The row that closes a frame yields two results (its upper
// neighbour and itself), or one if the frame is a single row high. Throughput:
// one row per cycle while in_stall is low; a closing row places two results
// in the four-entry output queue, which drains one per cycle while out_stall
// is low, so the queue alone decides when in_stall rises. The neighbour counts
// are formed combinationally in a row of column cells, each talking to its two neighbours.
// Reset clears the row history, the row count and the queue, and returns the
// width and height to 64. While out_stall is high the head result holds and
// the queue fills; in_stall rises once fewer than two entries are free.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_engine_top #(
  parameter int GRID_WIDTH_MAX  = 64,
  parameter int GRID_HEIGHT_MAX = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input rows
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [lgre_pkg::ROW_W-1:0]          in_row_bits,
  // Result rows
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [lgre_pkg::ROW_W-1:0]               out_next_row_bits,
  output logic [lgre_pkg::ROW_INDEX_W-1:0]         out_row_index,
  output logic                                     out_last_row,
  // Configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lgre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lgre_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lgre_pkg::*;

  // The row counter only needs to hold values below the height limit.
  localparam int ROW_CNT_W = (GRID_HEIGHT_MAX > 1) ? $clog2(GRID_HEIGHT_MAX) : 1;
  // Comparison width covers both the height register and the height limit.
  localparam int HGT_CMP_W = (ROW_CNT_W + 1 > GRID_HEIGHT_W) ? ROW_CNT_W + 1
                                                               : GRID_HEIGHT_W;

  logic [GRID_WIDTH_W-1:0]  grid_width_r, grid_width_nxt;
  logic [GRID_HEIGHT_W-1:0] grid_height_r, grid_height_nxt;
  logic [ROW_CNT_W-1:0]     rows_taken_r, rows_taken_nxt;

  logic                 in_accept;
  logic                 cfg_accept;
  logic [HGT_CMP_W-1:0] hgt_ext;
  logic [HGT_CMP_W-1:0] hgt_act;
  logic                 closes;
  logic [ROW_CNT_W-1:0] idx_prev;

  cell_ctl_t  ctl;
  col_bits_t  col_bits [GRID_WIDTH_MAX];
  logic [ROW_W-1:0] act_mask;
  logic [ROW_W-1:0] row_a;
  logic [ROW_W-1:0] row_b;

  result_t    res_a;
  result_t    res_b;
  result_t    head;
  fifo_stat_t fifo_stat;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_accept) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_nxt  = cfg_data[GRID_WIDTH_W-1:0];
        CFG_GRID_HEIGHT: grid_height_nxt = cfg_data[GRID_HEIGHT_W-1:0];
        default:         grid_width_nxt  = grid_width_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame control: a height of zero acts as one, and the height saturates at
  // the configured limit.
  // ---------------------------------------------------------------------------
  assign in_stall  = !fifo_stat.room_two;
  assign in_accept = in_valid && !in_stall;

  assign hgt_ext = HGT_CMP_W'(grid_height_r);

  always_comb begin
    priority if (hgt_ext == '0) begin
      hgt_act = HGT_CMP_W'(1);
    end else if (hgt_ext > HGT_CMP_W'(GRID_HEIGHT_MAX)) begin
      hgt_act = HGT_CMP_W'(GRID_HEIGHT_MAX);
    end else begin
      hgt_act = hgt_ext;
    end
  end

  assign closes   = (HGT_CMP_W'(rows_taken_r) + HGT_CMP_W'(1)) >= hgt_act;
  assign idx_prev = rows_taken_r - ROW_CNT_W'(1);

  always_comb begin
    rows_taken_nxt = rows_taken_r;
    if (in_accept) begin
      if (closes) begin
        rows_taken_nxt = '0;
      end else begin
        rows_taken_nxt = rows_taken_r + ROW_CNT_W'(1);
      end
    end
  end

  assign ctl.load  = in_accept;
  assign ctl.clear = closes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      rows_taken_r  <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      rows_taken_r  <= rows_taken_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Row of column cells. Each cell sees its two neighbours' masked bits; the
  // columns beyond either edge are dead. Columns past the cell row give zero.
  // ---------------------------------------------------------------------------
  for (genvar x = 0; x < ROW_W; x++) begin : g_col
    if (x < GRID_WIDTH_MAX) begin : g_cell
      col_bits_t left_bits;
      col_bits_t right_bits;

      if (x == 0) begin : g_left_edge
        assign left_bits = '0;
      end else begin : g_left_cell
        assign left_bits = col_bits[x-1];
      end

      if (x == GRID_WIDTH_MAX - 1) begin : g_right_edge
        assign right_bits = '0;
      end else begin : g_right_cell
        assign right_bits = col_bits[x+1];
      end

      assign act_mask[x] = (grid_width_r > GRID_WIDTH_W'(x));

      lgre_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .active     (act_mask[x]),
        .in_bit     (in_row_bits[x]),
        .ctl        (ctl),
        .left_bits  (left_bits),
        .right_bits (right_bits),
        .own_bits   (col_bits[x]),
        .res_a      (row_a[x]),
        .res_b      (row_b[x])
      );
    end else begin : g_unused
      assign act_mask[x] = 1'b0;
      assign row_a[x]    = 1'b0;
      assign row_b[x]    = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Results: the row above the newest one while a frame is open, and on the
  // closing row also the final row of the frame.
  // ---------------------------------------------------------------------------
  assign res_a.next_row_bits = row_a;
  assign res_a.row_index     = ROW_INDEX_W'(idx_prev);
  assign res_a.last_row      = 1'b0;

  assign res_b.next_row_bits = row_b;
  assign res_b.row_index     = ROW_INDEX_W'(rows_taken_r);
  assign res_b.last_row      = 1'b1;

  lgre_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_a     (in_accept && (rows_taken_r != '0)),
    .data_a     (res_a),
    .push_b     (in_accept && closes),
    .data_b     (res_b),
    .pop        (!out_stall),
    .head       (head),
    .head_valid (out_valid),
    .stat       (fifo_stat)
  );

  assign out_next_row_bits = head.next_row_bits;
  assign out_row_index     = head.row_index;
  assign out_last_row      = head.last_row;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.level <= FIFO_LVL_W'(FIFO_DEPTH))
    else $error("result queue holds more entries than its depth");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && closes |=> rows_taken_r == '0)
    else $error("row count not cleared after the closing row");

  a_dead_columns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_row_bits & ~act_mask) == '0)
    else $error("live cell reported outside the active width");

  // The first row of a frame that does not close it produces no result.
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && ((rows_taken_r != '0) || closes) |=> fifo_stat.level != '0)
    else $error("accepted row left the result queue empty");

endmodule

`default_nettype wire

### rtl/core/lgre_cell.sv
// One column cell: holds two rows of history and evaluates both result rows.
`timescale 1ns / 1ps
`default_nettype none

module lgre_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               active,
  input  wire logic               in_bit,
  input  wire lgre_pkg::cell_ctl_t ctl,
  input  wire lgre_pkg::col_bits_t left_bits,
  input  wire lgre_pkg::col_bits_t right_bits,
  output lgre_pkg::col_bits_t      own_bits,
  output logic                     res_a,
  output logic                     res_b
);
  import lgre_pkg::*;

  logic upper_r, upper_nxt;
  logic middle_r, middle_nxt;
  logic [NB_CNT_W-1:0] cnt_a;
  logic [NB_CNT_W-1:0] cnt_b;

  assign own_bits.upper  = upper_r & active;
  assign own_bits.middle = middle_r & active;
  assign own_bits.cur    = in_bit & active;

  // Row A: middle row with upper above and the incoming row below.
  assign cnt_a = NB_CNT_W'(left_bits.upper) + NB_CNT_W'(own_bits.upper)
               + NB_CNT_W'(right_bits.upper) + NB_CNT_W'(left_bits.middle)
               + NB_CNT_W'(right_bits.middle) + NB_CNT_W'(left_bits.cur)
               + NB_CNT_W'(own_bits.cur) + NB_CNT_W'(right_bits.cur);

  // Row B: incoming row as the last of the frame, with dead cells below.
  assign cnt_b = NB_CNT_W'(left_bits.middle) + NB_CNT_W'(own_bits.middle)
               + NB_CNT_W'(right_bits.middle) + NB_CNT_W'(left_bits.cur)
               + NB_CNT_W'(right_bits.cur);

  assign res_a = active & life_rule(own_bits.middle, cnt_a);
  assign res_b = active & life_rule(own_bits.cur, cnt_b);

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    if (ctl.load) begin
      if (ctl.clear) begin
        upper_nxt  = 1'b0;
        middle_nxt = 1'b0;
      end else begin
        upper_nxt  = own_bits.middle;
        middle_nxt = own_bits.cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lgre_out_fifo.sv
// Small result queue taking up to two results and giving one per cycle while pop is high.
`timescale 1ns / 1ps
`default_nettype none

module lgre_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_a,
  input  wire lgre_pkg::result_t data_a,
  input  wire logic              push_b,
  input  wire lgre_pkg::result_t data_b,
  input  wire logic              pop,
  output lgre_pkg::result_t      head,
  output logic                   head_valid,
  output lgre_pkg::fifo_stat_t   stat
);
  import lgre_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_LVL_W-1:0] level_r, level_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_b;
  logic                  do_pop;

  assign do_pop     = pop && (level_r != '0);
  assign wr_ptr_b   = wr_ptr_r + FIFO_PTR_W'(push_a);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
  assign level_nxt  = level_r + FIFO_LVL_W'(push_a) + FIFO_LVL_W'(push_b)
                    - FIFO_LVL_W'(do_pop);

  assign head          = mem_r[rd_ptr_r];
  assign head_valid    = (level_r != '0);
  assign stat.level    = level_r;
  assign stat.room_two = (level_r <= FIFO_LVL_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      mem_r[wr_ptr_b] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the Life generation row engine, with a built-in row predictor.
`timescale 1ns / 1ps

module tb_top;
  import lgre_pkg::*;

  localparam int HEIGHT_CAP     = 4096;  // tallest frame the block counts
  localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES   = 10;    // quiet cycles after the last result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int MAX_PRINTED    = 40;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [ROW_W-1:0]       in_row_bits = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [ROW_W-1:0]       out_next_row_bits;
  logic [ROW_INDEX_W-1:0] out_row_index;
  logic                   out_last_row;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = CFG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  life_generation_row_engine_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_row_bits       (in_row_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_next_row_bits (out_next_row_bits),
    .out_row_index     (out_row_index),
    .out_last_row      (out_last_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor copy of the registers and of the row history.
  logic [GRID_WIDTH_W-1:0]  grid_width_q  = GRID_WIDTH_RST;
  logic [GRID_HEIGHT_W-1:0] grid_height_q = GRID_HEIGHT_RST;
  logic [ROW_W-1:0]         hist_upper    = '0;
  logic [ROW_W-1:0]         hist_middle   = '0;
  int unsigned              rows_in_frame = 0;

  result_t     next_rows_due[$];
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned err_count       = 0;
  int unsigned rows_sent       = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned quiet_cycles    = 0;

  function automatic logic [ROW_W-1:0] live_columns();
    if (grid_width_q >= ROW_W)
      return '1;
    return (64'd1 << grid_width_q) - 64'd1;
  endfunction

  function automatic int unsigned frame_rows();
    if (grid_height_q == 0)
      return 1;
    if (grid_height_q > HEIGHT_CAP)
      return HEIGHT_CAP;
    return 32'(grid_height_q);
  endfunction

  // One generation step of the middle row; cells outside the mask are dead.
  function automatic logic [ROW_W-1:0] next_generation(input logic [ROW_W-1:0] above,
                                                       input logic [ROW_W-1:0] mid,
                                                       input logic [ROW_W-1:0] below,
                                                       input logic [ROW_W-1:0] cols);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] born;
    logic [ROW_W-1:0] nbr [8];
    int               cnt;
    a = above & cols;
    m = mid & cols;
    b = below & cols;
    nbr[0] = a << 1;
    nbr[1] = a;
    nbr[2] = a >> 1;
    nbr[3] = m << 1;
    nbr[4] = m >> 1;
    nbr[5] = b << 1;
    nbr[6] = b;
    nbr[7] = b >> 1;
    born = '0;
    for (int x = 0; x < ROW_W; x++) begin
      cnt = 0;
      for (int k = 0; k < 8; k++)
        cnt += nbr[k][x];
      born[x] = (cnt == BIRTH_CNT) || (m[x] && (cnt == SURVIVE_CNT));
    end
    return born & cols;
  endfunction

  // Works out the results that one accepted row causes and advances the history.
  task automatic predict_row(input logic [ROW_W-1:0] bits);
    logic [ROW_W-1:0] cols;
    logic [ROW_W-1:0] cur;
    result_t          res;
    cols = live_columns();
    cur  = bits & cols;
    if (rows_in_frame > 0) begin
      res.next_row_bits = next_generation(hist_upper, hist_middle, cur, cols);
      res.row_index     = ROW_INDEX_W'(rows_in_frame - 1);
      res.last_row      = 1'b0;
      next_rows_due.push_back(res);
    end
    if (rows_in_frame + 1 >= frame_rows()) begin
      res.next_row_bits = next_generation(hist_middle, cur, '0, cols);
      res.row_index     = ROW_INDEX_W'(rows_in_frame);
      res.last_row      = 1'b1;
      next_rows_due.push_back(res);
      hist_upper    = '0;
      hist_middle   = '0;
      rows_in_frame = 0;
    end else begin
      hist_upper    = hist_middle;
      hist_middle   = cur;
      rows_in_frame++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Presents one row and holds it until the transfer, then idles at random.
  task automatic send_row(input logic [ROW_W-1:0] bits);
    in_valid    <= 1'b1;
    in_row_bits <= bits;
    do @(posedge clk); while (in_stall);
    predict_row(bits);
    rows_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Register writes wait until every due result has left the block.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (next_rows_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_WIDTH)
      grid_width_q = value[GRID_WIDTH_W-1:0];
    else
      grid_height_q = value;
    cfg_writes++;
  endtask

  // Only the low seven data bits carry the width; the rest are filled at random.
  task automatic write_width(input int unsigned cols);
    write_register(CFG_GRID_WIDTH,
                   {(CFG_DATA_W-GRID_WIDTH_W)'($urandom_range(63)), GRID_WIDTH_W'(cols)});
  endtask

  task automatic set_grid(input int unsigned cols, input int unsigned rows);
    write_width(cols);
    write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(rows));
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r1;
    logic [ROW_W-1:0] r2;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2:       return r1 & r2 & {$urandom, $urandom};
      3:       return r1 | r2;
      4:       return 64'd7 << $urandom_range(ROW_W - 1);
      default: return r1;
    endcase
  endfunction

  // Rows start under the reset registers, then the height drops to the number of
  // rows already taken, so the next row has to close the frame.
  task automatic test_reset_and_mid_frame_height();
    send_row('1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(2));
    send_row(64'h0F0F_0F0F_0F0F_0F0F);
  endtask

  // A blinker in a narrow grid, then live cells against both side walls.
  task automatic test_known_patterns();
    set_grid(5, 3);
    send_row(64'h0);
    send_row(64'b01110);
    send_row(64'h0);
    set_grid(64, 3);
    repeat (3) send_row(64'hC000_0000_0000_0003);
  endtask

  task automatic test_width_extremes();
    set_grid(0, 2);
    repeat (2) send_row('1);
    set_grid(1, 2);
    repeat (2) send_row('1);
    set_grid(127, 2);
    repeat (2) send_row('1);
    set_grid(65, 1);
    send_row(64'h8000_0000_0000_0001);
  endtask

  task automatic test_height_extremes();
    set_grid(64, 0);
    send_row('1);
    send_row(64'h0000_0007_0000_0000);
    write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(1));
    send_row(64'h0707_0707_0707_0707);
  endtask

  // Mostly whole frames with random rows; now and then a frame is cut short
  // and the registers change before it closes.
  task automatic test_random_frames(input int unsigned n_rows, input int unsigned sp,
                                    input int unsigned rp);
    int unsigned target;
    int unsigned rows_left;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    target = rows_sent + n_rows;
    while (rows_sent < target) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0:       write_width(0);
          1:       write_width($urandom_range(1, 3));
          2:       write_width(64);
          3:       write_width($urandom_range(65, 127));
          default: write_width($urandom_range(4, 63));
        endcase
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(0));
          1:       write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(1));
          2:       write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(2));
          3:       write_register(CFG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(4096, 8191)));
          default: write_register(CFG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(3, 20)));
        endcase
      end
      rows_left = (rows_in_frame >= frame_rows()) ? 1 : frame_rows() - rows_in_frame;
      if (rows_left > 24)
        rows_left = $urandom_range(1, 24);
      else if (rows_left > 1 && $urandom_range(9) == 0)
        rows_left = $urandom_range(1, rows_left - 1);
      repeat (rows_left) send_row(random_row());
    end
  endtask

  // Result side: checks each transfer against the oldest due row and stalls at random.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (next_rows_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, row %0d bits %h",
                                  out_row_index, out_next_row_bits));
      end else begin
        want = next_rows_due.pop_front();
        if (out_next_row_bits !== want.next_row_bits)
          report_mismatch($sformatf("row %0d bits %h, want %h", want.row_index,
                                    out_next_row_bits, want.next_row_bits));
        if (out_row_index !== want.row_index)
          report_mismatch($sformatf("row index %0d, want %0d", out_row_index,
                                    want.row_index));
        if (out_last_row !== want.last_row)
          report_mismatch($sformatf("row %0d last flag %b, want %b", want.row_index,
                                    out_last_row, want.last_row));
        results_checked++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, next_rows_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 62;
    test_reset_and_mid_frame_height();
    test_known_patterns();
    test_width_extremes();
    test_height_extremes();
    test_random_frames(460, 30, 62);
    test_random_frames(460, 62, 30);
    test_random_frames(460, 0, 0);
    in_valid <= 1'b0;
    while (next_rows_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d input rows, %0d result rows and %0d register writes.",
             rows_sent, results_checked, cfg_writes);
    $display("Widths 0 to 127, heights 0 to 8191 and height changes in the middle of a frame.");
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lgre_pkg.sv
rtl/core/lgre_cell.sv
rtl/core/lgre_out_fifo.sv
rtl/core/life_generation_row_engine_top.sv
sim/tb_top.sv
